// File: rtl/vertex_transform_project_assert.svh
// ----------------------------------------------------------------------------
// Vertex transform assertion macros
// Shared assertion wrappers, sampled on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_PROJECT_ASSERT_SVH
`define VERTEX_TRANSFORM_PROJECT_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define VTP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("vertex transform assertion failed");

// A condition that implies another in the next cycle.
`define VTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vertex transform assertion failed");

`endif

// File: rtl/vtp_pkg.sv
// ----------------------------------------------------------------------------
// Vertex transform package
// Word types, register indexes and the rounded Q14 product helper.
// ----------------------------------------------------------------------------
package vtp_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DepthW = 15;
  localparam int unsigned RegW   = 48;
  localparam int unsigned QuotW  = 13;
  localparam int unsigned DivW   = 16;

  localparam logic [DepthW-1:0] DepthMin  = 15'd64;
  localparam logic [DivW-1:0]   DepthBias = 16'h0200;
  // The reciprocal numerator 0x400000 shifted down by QuotW bits.
  localparam logic [DivW-1:0]   RecipTop  = 16'h0200;

  localparam logic [7:0] RegMatX  = 8'd0;
  localparam logic [7:0] RegMatY  = 8'd1;
  localparam logic [7:0] RegMatZ  = 8'd2;
  localparam logic [7:0] RegTrans = 8'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
    logic [DepthW-1:0]        depth;
  } out_word_t;

  typedef struct packed {
    logic signed [CoordW-1:0] rx;
    logic signed [CoordW-1:0] ry;
    logic [DepthW-1:0]        depth;
  } mid_word_t;

  typedef struct packed {
    logic [DivW-1:0]          rem;
    logic [DivW-1:0]          dvs;
    logic [QuotW-1:0]         quo;
    logic signed [CoordW-1:0] rx;
    logic signed [CoordW-1:0] ry;
    logic [DepthW-1:0]        depth;
  } div_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Adds one half and floors by 14 bits, keeping the low 16 bits.
  function automatic logic [CoordW-1:0] qround(input logic signed [31:0] p);
    logic [32:0] s;
    s = {p[31], p} + 33'h0_0000_2000;
    return s[29:14];
  endfunction

endpackage

// File: rtl/vtp_front.sv
// ----------------------------------------------------------------------------
// Vertex transform front end
// Accepts vertices, forms the nine matrix products, the translated sums and the depth floor.
// ----------------------------------------------------------------------------
module vtp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  vtp_pkg::in_word_t    in_word_i,
  input  logic [47:0]          mat_x_i,
  input  logic [47:0]          mat_y_i,
  input  logic [47:0]          mat_z_i,
  input  logic [47:0]          trans_i,
  output logic                 push_o,
  output vtp_pkg::mid_word_t   push_word_o,
  input  logic                 queue_full_i
);

  logic                en;
  logic                p_valid_q;
  logic signed [31:0]  prod_q [9];
  logic signed [15:0]  coef [9];
  logic signed [15:0]  pt [3];
  logic                s_valid_q;
  vtp_pkg::mid_word_t  s_word_q;
  logic [15:0]         sum [3];

  assign en         = !(s_valid_q && queue_full_i);
  assign in_stall_o = !en;

  always_comb begin
    pt[0] = in_word_i.point_x;
    pt[1] = in_word_i.point_y;
    pt[2] = in_word_i.point_z;
    for (int c = 0; c < 3; c++) begin
      coef[c]     = mat_x_i[16*c +: 16];
      coef[3 + c] = mat_y_i[16*c +: 16];
      coef[6 + c] = mat_z_i[16*c +: 16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        prod_q[k] <= pt[k % 3] * coef[k];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = vtp_pkg::qround(prod_q[3*r]) + vtp_pkg::qround(prod_q[3*r + 1])
             + vtp_pkg::qround(prod_q[3*r + 2]) + trans_i[16*r +: 16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_word_q.rx <= sum[0];
      s_word_q.ry <= sum[1];
      if ($signed(sum[2]) < $signed({1'b0, vtp_pkg::DepthMin})) begin
        s_word_q.depth <= vtp_pkg::DepthMin;
      end else begin
        s_word_q.depth <= sum[2][14:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= in_valid_i;
      s_valid_q <= p_valid_q;
    end
  end

  assign push_o      = s_valid_q && !queue_full_i;
  assign push_word_o = s_word_q;

endmodule

// File: rtl/vtp_queue.sv
// ----------------------------------------------------------------------------
// Vertex transform queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module vtp_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  vtp_pkg::mid_word_t      push_word_i,
  input  logic                    pop_i,
  output vtp_pkg::mid_word_t      pop_word_o,
  output vtp_pkg::queue_status_t  status_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  vtp_pkg::mid_word_t mem_q [Depth];
  logic [AddrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign pop_word_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/vtp_back.sv
// ----------------------------------------------------------------------------
// Vertex transform back end
// Pipelined reciprocal of the biased depth, then the perspective scaling.
// ----------------------------------------------------------------------------
module vtp_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    queue_valid_i,
  output logic                    pop_o,
  input  vtp_pkg::mid_word_t      queue_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output vtp_pkg::out_word_t      out_word_o
);

  localparam int unsigned Steps = vtp_pkg::QuotW;

  logic                en;
  logic                dv_q [Steps + 1];
  vtp_pkg::div_word_t  dw_q [Steps + 1];
  logic                m_valid_q;
  logic signed [29:0]  mx_q, my_q;
  logic [14:0]         m_depth_q;
  logic                o_valid_q;
  vtp_pkg::out_word_t  o_word_q;

  assign en    = !o_valid_q || !out_stall_i;
  assign pop_o = en && queue_valid_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dw_q[0].rem   <= vtp_pkg::RecipTop;
      dw_q[0].dvs   <= vtp_pkg::DepthBias + {1'b0, queue_word_i.depth};
      dw_q[0].quo   <= '0;
      dw_q[0].rx    <= queue_word_i.rx;
      dw_q[0].ry    <= queue_word_i.ry;
      dw_q[0].depth <= queue_word_i.depth;
    end
  end

  for (genvar k = 1; k <= Steps; k++) begin : g_div
    logic [16:0] trial;
    assign trial = {dw_q[k-1].rem, 1'b0};
    always_ff @(posedge clk_i) begin
      if (en) begin
        dw_q[k].dvs   <= dw_q[k-1].dvs;
        dw_q[k].rx    <= dw_q[k-1].rx;
        dw_q[k].ry    <= dw_q[k-1].ry;
        dw_q[k].depth <= dw_q[k-1].depth;
        if (trial >= {1'b0, dw_q[k-1].dvs}) begin
          dw_q[k].rem <= 16'(trial - {1'b0, dw_q[k-1].dvs});
          dw_q[k].quo <= {dw_q[k-1].quo[vtp_pkg::QuotW-2:0], 1'b1};
        end else begin
          dw_q[k].rem <= trial[15:0];
          dw_q[k].quo <= {dw_q[k-1].quo[vtp_pkg::QuotW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q      <= dw_q[Steps].rx * $signed({1'b0, dw_q[Steps].quo});
      my_q      <= dw_q[Steps].ry * $signed({1'b0, dw_q[Steps].quo});
      m_depth_q <= dw_q[Steps].depth;
      o_word_q.screen_x <= vtp_pkg::qround(32'(mx_q));
      o_word_q.screen_y <= vtp_pkg::qround(32'(my_q));
      o_word_q.depth    <= m_depth_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Steps; k++) begin
        dv_q[k] <= 1'b0;
      end
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en) begin
      dv_q[0] <= queue_valid_i;
      for (int k = 1; k <= Steps; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
      m_valid_q <= dv_q[Steps];
      o_valid_q <= m_valid_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_word_o  = o_word_q;

endmodule

// File: rtl/vertex_transform_project.sv
// ----------------------------------------------------------------------------
// Vertex transform with perspective projection
// Rotates, translates and projects one vertex per word.
//
//   Channel  Direction  Handshake            Word
//   in       input      in_valid / in_stall  point_x, point_y, point_z
//   out      output     out_valid/out_stall  screen_x, screen_y, depth
//   cfg      input      cfg_valid/cfg_ready  register index, 48-bit data
//
// One word is accepted per cycle while the input is not stalled. The path
// runs through two front stages for the products and sums, the queue, one
// divisor load stage, thirteen radix-2 reciprocal stages, one scaling multiply
// stage and the output register.
// Reset clears all control state and the four registers to zero.
// An output stall freezes the back end; the queue then absorbs front words
// until it fills, after which the input stalls.
// ----------------------------------------------------------------------------
module vertex_transform_project #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vtp_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vtp_pkg::out_word_t  out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [47:0]         cfg_data_i
);

  `include "vertex_transform_project_assert.svh"

  logic [47:0]             mat_x_q, mat_y_q, mat_z_q, trans_q;
  logic                    push, pop;
  vtp_pkg::mid_word_t      push_word, pop_word;
  vtp_pkg::queue_status_t  q_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_x_q <= '0;
      mat_y_q <= '0;
      mat_z_q <= '0;
      trans_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vtp_pkg::RegMatX:  mat_x_q <= cfg_data_i;
        vtp_pkg::RegMatY:  mat_y_q <= cfg_data_i;
        vtp_pkg::RegMatZ:  mat_z_q <= cfg_data_i;
        vtp_pkg::RegTrans: trans_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vtp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .mat_x_i      (mat_x_q),
    .mat_y_i      (mat_y_q),
    .mat_z_i      (mat_z_q),
    .trans_i      (trans_q),
    .push_o       (push),
    .push_word_o  (push_word),
    .queue_full_i (q_status.full)
  );

  vtp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .pop_word_o  (pop_word),
    .status_o    (q_status)
  );

  vtp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_valid_i (!q_status.empty),
    .pop_o         (pop),
    .queue_word_i  (pop_word),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o)
  );

  `VTP_ASSERT(a_depth_floor, !out_valid_o || (out_word_o.depth >= vtp_pkg::DepthMin))
  `VTP_ASSERT(a_queue_status, !(q_status.full && q_status.empty))
  `VTP_ASSERT(a_pop_not_empty, !pop || !q_status.empty)
  `VTP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))

endmodule
